FILE: rtl/core/qrs_pkg.sv
package qrs_pkg;

  localparam int COEF_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int OUT_W    = 33;
  // b*b - 4ac needs two bits beyond the products
  localparam int PROD_W   = 2 * COEF_W;
  localparam int DISC_W   = PROD_W + 3;
  // radicand: nonnegative discriminant, padded to an even width
  localparam int RAD_W    = PROD_W + 2;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int SREM_W   = ROOT_W + 2;
  // -b +/- s
  localparam int NUM_W    = ROOT_W + 2;
  localparam int MAG_W    = ROOT_W;
  localparam int DVD_W    = MAG_W + FRAC_W;
  localparam int DIVS_W   = COEF_W + 1;

  typedef enum logic [1:0] {
    ST_A_ZERO  = 2'd0,
    ST_NO_REAL = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_TWO     = 2'd3
  } status_e;

  typedef struct packed {
    status_e                   status;
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
  } sq_side_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] neg;   // [1] plus root, [0] minus root
  } div_side_t;

endpackage

FILE: rtl/core/quadratic_root_solver.sv
// Quadratic root solver: a*x^2 + b*x + c with signed 16-bit coefficients.
// Input channel: in_valid_i/in_ready_o carry one beat of coef_a/b/c.
// Output channel: out_valid_o/out_ready_i carry one beat of root_status
// and the two roots (33-bit signed, 16 fraction bits), in input order.
// Status: a zero, no real roots, double root, two roots; roots read zero
// when none exist.
// Pipeline, input beat to output beat: 2 product/discriminant stages,
// 17 square root cells (one root bit each), one numerator stage,
// 33 divider cells (one quotient bit each for both roots), and the
// output register.
// Throughput: one beat per cycle while the skid buffer is empty; every
// stage is a register and nothing iterates in place.
// Stall: the output register is backed by a one-beat skid buffer. The
// pipeline advances while the skid buffer is empty, so a beat is still
// accepted in the cycle the receiver first stalls; in_ready_o then drops
// until the output register drains the skid buffer.
// Reset: all valid bits clear, so both channels come up empty.
module quadratic_root_solver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_a_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_b_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_c_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          root_status_o,
  output logic signed [qrs_pkg::OUT_W-1:0]    root_plus_o,
  output logic signed [qrs_pkg::OUT_W-1:0]    root_minus_o
);
  import qrs_pkg::*;

  localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic adv;   // whole pipeline moves while the skid buffer is empty

  // ---- stage 1: products ----
  logic                      v1_q;
  logic signed [COEF_W-1:0]  a1_q, b1_q;
  logic signed [PROD_W-1:0]  bb1_q, ac1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q  <= coef_a_i;
      b1_q  <= coef_b_i;
      bb1_q <= coef_b_i * coef_b_i;
      ac1_q <= coef_a_i * coef_c_i;
    end
  end

  // ---- stage 2: discriminant and status ----
  logic signed [DISC_W-1:0] disc_d;
  status_e                  status_d;
  logic [RAD_W-1:0]         rad_d;
  logic                     v2_q;
  sq_side_t                 side2_q;
  logic [RAD_W-1:0]         rad2_q;

  always_comb begin
    disc_d = DISC_W'(bb1_q) - (DISC_W'(ac1_q) <<< 2);
    rad_d  = '0;
    if (a1_q == '0) begin
      status_d = ST_A_ZERO;
    end else if (disc_d[DISC_W-1]) begin
      status_d = ST_NO_REAL;
    end else if (disc_d == '0) begin
      status_d = ST_DOUBLE;
    end else begin
      status_d = ST_TWO;
      rad_d    = disc_d[RAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= '{status: status_d, a: a1_q, b: b1_q};
      rad2_q  <= rad_d;
    end
  end

  // ---- square root chain ----
  logic     [ROOT_W:0]              sq_v;
  sq_side_t [ROOT_W:0]              sq_side;
  logic     [ROOT_W:0][RAD_W-1:0]   sq_rad;
  logic     [ROOT_W:0][SREM_W-1:0]  sq_rem;
  logic     [ROOT_W:0][ROOT_W-1:0]  sq_root;

  assign sq_v[0]    = v2_q;
  assign sq_side[0] = side2_q;
  assign sq_rad[0]  = rad2_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[k]),
      .side_i  (sq_side[k]),
      .rad_i   (sq_rad[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .valid_o (sq_v[k+1]),
      .side_o  (sq_side[k+1]),
      .rad_o   (sq_rad[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1])
    );
  end

  // ---- numerator stage: -b +/- s, magnitudes and signs ----
  sq_side_t                 sq_last;
  logic signed [NUM_W-1:0]  nb, np, nm, ap, am;
  logic signed [DIVS_W-1:0] a_x, a_abs;
  logic                     v3_q;
  div_side_t                side3_q;
  logic [DIVS_W-1:0]        dvs3_q;
  logic [1:0][DVD_W-1:0]    dvd3_q;

  always_comb begin
    sq_last = sq_side[ROOT_W];
    nb      = -NUM_W'(sq_last.b);
    np      = nb + $signed({2'b00, sq_root[ROOT_W]});
    nm      = nb - $signed({2'b00, sq_root[ROOT_W]});
    ap      = np[NUM_W-1] ? -np : np;
    am      = nm[NUM_W-1] ? -nm : nm;
    a_x     = DIVS_W'(sq_last.a);
    a_abs   = a_x[DIVS_W-1] ? -a_x : a_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q.status <= sq_last.status;
      side3_q.neg    <= {np[NUM_W-1] ^ sq_last.a[COEF_W-1],
                         nm[NUM_W-1] ^ sq_last.a[COEF_W-1]};
      dvs3_q         <= {a_abs[DIVS_W-2:0], 1'b0};
      dvd3_q[1]      <= {ap[MAG_W-1:0], {FRAC_W{1'b0}}};
      dvd3_q[0]      <= {am[MAG_W-1:0], {FRAC_W{1'b0}}};
    end
  end

  // ---- divider chain ----
  logic      [DVD_W:0]                     dv_v;
  div_side_t [DVD_W:0]                     dv_side;
  logic      [DVD_W:0][DIVS_W-1:0]         dv_dvs;
  logic      [DVD_W:0][1:0][DIVS_W-1:0]    dv_rem;
  logic      [DVD_W:0][1:0][DVD_W-1:0]     dv_dq;

  assign dv_v[0]    = v3_q;
  assign dv_side[0] = side3_q;
  assign dv_dvs[0]  = dvs3_q;
  assign dv_rem[0]  = '0;
  assign dv_dq[0]   = dvd3_q;

  for (genvar k = 0; k < DVD_W; k++) begin : g_div
    qrs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_v[k]),
      .side_i  (dv_side[k]),
      .dvs_i   (dv_dvs[k]),
      .rem_i   (dv_rem[k]),
      .dq_i    (dv_dq[k]),
      .valid_o (dv_v[k+1]),
      .side_o  (dv_side[k+1]),
      .dvs_o   (dv_dvs[k+1]),
      .rem_o   (dv_rem[k+1]),
      .dq_o    (dv_dq[k+1])
    );
  end

  // ---- sign, saturation, zeroing ----
  function automatic logic [OUT_W-1:0] fix_root(logic neg, logic [DVD_W-1:0] q);
    logic [OUT_W:0] qx;
    logic [OUT_W:0] neg_q;
    qx    = (OUT_W+1)'(q);
    neg_q = -qx;
    if (!neg) begin
      fix_root = (qx > (OUT_W+1)'(POS_MAX)) ? POS_MAX : qx[OUT_W-1:0];
    end else begin
      fix_root = (qx > (OUT_W+1)'(NEG_MIN)) ? NEG_MIN : neg_q[OUT_W-1:0];
    end
  endfunction

  div_side_t        dv_last;
  logic             has_roots;
  logic [OUT_W-1:0] plus_d, minus_d;

  always_comb begin
    dv_last   = dv_side[DVD_W];
    has_roots = (dv_last.status == ST_DOUBLE) || (dv_last.status == ST_TWO);
    plus_d    = has_roots ? fix_root(dv_last.neg[1], dv_dq[DVD_W][1]) : '0;
    minus_d   = has_roots ? fix_root(dv_last.neg[0], dv_dq[DVD_W][0]) : '0;
  end

  // ---- output register and skid buffer ----
  logic             out_valid_q, skid_valid_q;
  logic             load_out;
  status_e          out_status_q, skid_status_q;
  logic [OUT_W-1:0] out_plus_q, out_minus_q, skid_plus_q, skid_minus_q;

  assign adv      = !skid_valid_q;
  assign load_out = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (adv) begin
      if (load_out) begin
        out_valid_q <= dv_v[DVD_W];
      end else if (dv_v[DVD_W]) begin
        skid_valid_q <= 1'b1;
      end
    end else if (load_out) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (load_out) begin
        out_status_q <= dv_last.status;
        out_plus_q   <= plus_d;
        out_minus_q  <= minus_d;
      end else begin
        skid_status_q <= dv_last.status;
        skid_plus_q   <= plus_d;
        skid_minus_q  <= minus_d;
      end
    end else if (load_out) begin
      out_status_q <= skid_status_q;
      out_plus_q   <= skid_plus_q;
      out_minus_q  <= skid_minus_q;
    end
  end

  assign in_ready_o    = adv;
  assign out_valid_o   = out_valid_q;
  assign root_status_o = out_status_q;
  assign root_plus_o   = out_plus_q;
  assign root_minus_o  = out_minus_q;

  // ---- checks ----
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid buffer holds a beat while output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q)
    else $error("skid beat lost under stall");

  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_status_o == ST_A_ZERO || root_status_o == ST_NO_REAL)
    |-> root_plus_o == '0 && root_minus_o == '0)
    else $error("nonzero root without real roots");

  a_double_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_status_o == ST_DOUBLE |-> root_plus_o == root_minus_o)
    else $error("double root with unequal roots");

endmodule

FILE: rtl/core/qrs_sqrt_cell.sv
// One result bit of the floored square root per cell.
module qrs_sqrt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  qrs_pkg::sq_side_t             side_i,
  input  logic [qrs_pkg::RAD_W-1:0]     rad_i,
  input  logic [qrs_pkg::SREM_W-1:0]    rem_i,
  input  logic [qrs_pkg::ROOT_W-1:0]    root_i,
  output logic                          valid_o,
  output qrs_pkg::sq_side_t             side_o,
  output logic [qrs_pkg::RAD_W-1:0]     rad_o,
  output logic [qrs_pkg::SREM_W-1:0]    rem_o,
  output logic [qrs_pkg::ROOT_W-1:0]    root_o
);
  import qrs_pkg::*;

  logic [SREM_W+1:0] rem_x;
  logic [SREM_W+1:0] trial;
  logic              ge;
  logic [SREM_W+1:0] rem_diff;
  logic [SREM_W-1:0] rem_d;
  logic [ROOT_W-1:0] root_d;
  logic [RAD_W-1:0]  rad_d;
  logic              valid_q;
  sq_side_t          side_q;
  logic [RAD_W-1:0]  rad_q;
  logic [SREM_W-1:0] rem_q;
  logic [ROOT_W-1:0] root_q;

  always_comb begin
    rem_x    = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    ge       = (rem_x >= trial);
    rem_diff = ge ? (rem_x - trial) : rem_x;
    rem_d    = rem_diff[SREM_W-1:0];
    root_d   = {root_i[ROOT_W-2:0], ge};
    rad_d    = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

FILE: rtl/core/qrs_div_cell.sv
// One quotient bit per cell, both roots side by side, shared divisor.
module qrs_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  qrs_pkg::div_side_t            side_i,
  input  logic [qrs_pkg::DIVS_W-1:0]    dvs_i,
  input  logic [1:0][qrs_pkg::DIVS_W-1:0] rem_i,
  input  logic [1:0][qrs_pkg::DVD_W-1:0]  dq_i,
  output logic                          valid_o,
  output qrs_pkg::div_side_t            side_o,
  output logic [qrs_pkg::DIVS_W-1:0]    dvs_o,
  output logic [1:0][qrs_pkg::DIVS_W-1:0] rem_o,
  output logic [1:0][qrs_pkg::DVD_W-1:0]  dq_o
);
  import qrs_pkg::*;

  logic [1:0][DIVS_W:0]   rem_x;
  logic [1:0][DIVS_W:0]   rem_diff;
  logic [1:0]             ge;
  logic [1:0][DIVS_W-1:0] rem_d;
  logic [1:0][DVD_W-1:0]  dq_d;
  logic                   valid_q;
  div_side_t              side_q;
  logic [DIVS_W-1:0]      dvs_q;
  logic [1:0][DIVS_W-1:0] rem_q;
  logic [1:0][DVD_W-1:0]  dq_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_x[l]    = {rem_i[l], dq_i[l][DVD_W-1]};
      ge[l]       = (rem_x[l] >= {1'b0, dvs_i});
      rem_diff[l] = ge[l] ? (rem_x[l] - {1'b0, dvs_i}) : rem_x[l];
      rem_d[l]    = rem_diff[l][DIVS_W-1:0];
      dq_d[l]     = {dq_i[l][DVD_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      dvs_q  <= dvs_i;
      rem_q  <= rem_d;
      dq_q   <= dq_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign dvs_o   = dvs_q;
  assign rem_o   = rem_q;
  assign dq_o    = dq_q;

endmodule

FILE: tb/tb_quadratic_root_solver.sv
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int LATENCY   = 54;
  localparam int N_RANDOM  = 1530;
  localparam longint CYCLE_LIMIT = 400000;

  // Expected root set for one beat.
  typedef struct packed {
    status_e                  status;
    logic signed [OUT_W-1:0]  plus;
    logic signed [OUT_W-1:0]  minus;
  } roots_t;

  // Keeps the roots still owed by the block, oldest first.
  class root_scoreboard;
    roots_t pending[$];
    int     mismatches;

    static function longint isqrt_floor(longint x);
      longint rem, res, bitv;
      rem  = x;
      res  = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > rem) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >>> 1) + bitv;
        end else begin
          res = res >>> 1;
        end
        bitv = bitv >>> 2;
      end
      return res;
    endfunction

    static function logic signed [OUT_W-1:0] fixed_root(longint num, longint a);
      longint q, hi, lo;
      q  = (num * (64'sd1 <<< FRAC_W)) / (2 * a);
      hi = (64'sd1 <<< (OUT_W - 1)) - 1;
      lo = -hi - 1;
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q[OUT_W-1:0];
    endfunction

    function void note_coefs(logic signed [COEF_W-1:0] ca, logic signed [COEF_W-1:0] cb,
                             logic signed [COEF_W-1:0] cc);
      longint a, b, c, disc, s;
      roots_t r;
      a = ca;
      b = cb;
      c = cc;
      r = '0;
      r.status = ST_A_ZERO;
      if (a != 0) begin
        disc = b * b - 4 * a * c;
        if (disc < 0) begin
          r.status = ST_NO_REAL;
        end else if (disc == 0) begin
          r.status = ST_DOUBLE;
          r.plus   = fixed_root(-b, a);
          r.minus  = r.plus;
        end else begin
          s = isqrt_floor(disc);
          r.status = ST_TWO;
          r.plus   = fixed_root(-b + s, a);
          r.minus  = fixed_root(-b - s, a);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_roots(logic [1:0] st, logic signed [OUT_W-1:0] rp,
                              logic signed [OUT_W-1:0] rm);
      roots_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: status %0d", st);
        return;
      end
      e = pending.pop_front();
      if (st != e.status || rp != e.plus || rm != e.minus) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d %0d %0d, got %0d %0d %0d",
                   e.status, e.plus, e.minus, st, rp, rm);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [COEF_W-1:0] coef_a_i = '0, coef_b_i = '0, coef_c_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] root_status_o;
  logic signed [OUT_W-1:0] root_plus_o, root_minus_o;

  root_scoreboard sb = new();
  longint cycles = 0;

  always #6 clk_i = ~clk_i;

  quadratic_root_solver uut (.*);

  // Cycle watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both channels sampled at the rising edge; scoreboard updated there.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_coefs(coef_a_i, coef_b_i, coef_c_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_roots(root_status_o, root_plus_o, root_minus_o);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 70);
  endfunction

  // Send one beat: raise valid at a falling edge, hold until accepted.
  task automatic send_beat(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                           logic signed [COEF_W-1:0] c);
    in_valid_i <= 1'b1;
    coef_a_i   <= a;
    coef_b_i   <= b;
    coef_c_i   <= c;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Random coefficient, biased toward small and extreme values so every
  // status shows up often.
  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return COEF_W'($urandom_range(0, 65535));
      1:       return COEF_W'($signed(COEF_W'($urandom_range(0, 16))) - 8);
      2:       return $urandom_range(0, 1) ? COEF_W'(16'sh7fff - $urandom_range(0, 3))
                                           : COEF_W'(16'sh8000 + $urandom_range(0, 3));
      default: return COEF_W'($signed(COEF_W'($urandom_range(0, 512))) - 256);
    endcase
  endfunction

  task automatic send_random_set();
    logic signed [COEF_W-1:0] a, b, c, k, m;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      // Build a perfect square: (k x + m)^2 -> double root (a zero when k is 0).
      k = COEF_W'($signed(COEF_W'($urandom_range(0, 200))) - 100);
      m = COEF_W'($signed(COEF_W'($urandom_range(0, 180))) - 90);
      a = k * k;
      b = COEF_W'(2 * k * m);
      c = m * m;
    end else begin
      a = rand_coef();
      b = rand_coef();
      c = rand_coef();
    end
    send_beat(a, b, c);
  endtask

  // Receiver ready pattern.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      repeat (n) @(negedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    int wait_cnt;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes and each status, including the case of a zero.
    send_beat(16'sh0000, 16'sh0005, 16'sh0003);
    send_beat(16'sh0000, 16'sh0000, 16'sh0000);
    send_beat(16'sh0001, 16'sh0000, 16'sh0001);
    send_beat(16'sh0001, 16'sh0002, 16'sh0001);
    send_beat(16'sh0001, -16'sh0003, 16'sh0002);
    send_beat(-16'sh0001, 16'sh0000, 16'sh0004);
    send_beat(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_beat(16'sh8000, 16'sh8000, 16'sh8000);
    send_beat(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_beat(16'sh7fff, 16'sh8000, 16'sh8000);
    send_beat(16'sh0001, 16'sh8000, 16'sh8000);
    send_beat(16'sh0001, 16'sh8000, 16'sh7fff);
    send_beat(-16'sh0001, 16'sh7fff, 16'sh0000);
    send_beat(16'sh0001, 16'sh8000, 16'sh0000);
    send_beat(16'shffff, 16'shffff, 16'shffff);
    send_beat(16'sh5555, 16'shaaaa, 16'sh5555);
    send_beat(16'shaaaa, 16'sh5555, 16'shaaaa);
    send_beat(16'sh0004, 16'sh0004, 16'sh0001);
    send_beat(16'sh0003, 16'sh0007, -16'sh0002);

    // Drain fully once before the random part.
    idle_sender(0);
    while (sb.pending.size() != 0) @(negedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) begin
      send_random_set();
      if ($urandom_range(0, 2) == 0) idle_sender(gap_len());
      if (i == N_RANDOM / 2) begin
        idle_sender(0);
        while (sb.pending.size() != 0) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    wait_cnt = 0;
    while (wait_cnt < 2 * LATENCY) begin
      @(negedge clk_i);
      wait_cnt++;
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_sqrt_cell.sv
rtl/core/qrs_div_cell.sv
rtl/core/quadratic_root_solver.sv
tb/tb_quadratic_root_solver.sv
